// ===== design/revolution_surface_tessellator_core_defines.svh =====
// ---------------------------------------------------------------------------
// Revolution surface tessellator assertion macros
// Shared concurrent assertion forms for the tessellator RTL.
// ---------------------------------------------------------------------------
`ifndef REVOLUTION_SURFACE_TESSELLATOR_CORE_DEFINES_SVH
`define REVOLUTION_SURFACE_TESSELLATOR_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside of reset.
`define RSURF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property on every rising clock edge, reset included.
`define RSURF_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== design/rsurf_pkg.sv =====
// ---------------------------------------------------------------------------
// Revolution surface tessellator package
// Shared types, microcode program, register codes and sine table builder.
// ---------------------------------------------------------------------------
package rsurf_pkg;

   // Parameter defaults
   localparam int MAX_ROTATIONS_DEF   = 64;
   localparam int MAX_PROFILE_DEF     = 64;
   localparam int SINE_TABLE_BITS_DEF = 10;

   // Field widths
   localparam int IDX_BITS   = 12;
   localparam int COORD_BITS = 16;
   localparam int CSR_BITS   = 16;
   localparam int CSR_IDX_BITS = 2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROTATION_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PROFILE_COUNT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANGLE_STEP     = 2'd2;

   // Register reset values
   localparam logic [6:0]  ROTATION_COUNT_RST = 7'd16;
   localparam logic [6:0]  PROFILE_COUNT_RST  = 7'd8;
   localparam logic [15:0] ANGLE_STEP_RST     = 16'd4096;

   typedef struct packed {
      logic [6:0]  rotation_count;
      logic [6:0]  profile_count;
      logic [15:0] angle_step;
   } cfg_type;

   typedef struct packed {
      logic [5:0]         point_index;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
   } point_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] vertex_index;
      logic signed [15:0]  rot_x;
      logic signed [15:0]  rot_y;
      logic signed [15:0]  rot_z;
      logic                faces_valid;
      logic [IDX_BITS-1:0] lower_v0;
      logic [IDX_BITS-1:0] lower_v1;
      logic [IDX_BITS-1:0] lower_v2;
      logic [IDX_BITS-1:0] upper_v0;
      logic [IDX_BITS-1:0] upper_v1;
      logic [IDX_BITS-1:0] upper_v2;
      logic                last_of_run;
   } result_type;

   // Sequencer to datapath strobes
   typedef struct packed {
      logic load;
      logic mul_cos;
      logic mul_sin;
      logic emit;
   } ctl_type;

   // Datapath to sequencer status
   typedef struct packed {
      logic last;
      logic out_free;
   } status_type;

   // Microcode
   localparam int STEP_BITS   = 3;
   localparam int UCODE_DEPTH = 1 << STEP_BITS;

   localparam logic [STEP_BITS-1:0] STEP_READ = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_MULC = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_MULS = 3'd2;
   localparam logic [STEP_BITS-1:0] STEP_EMIT = 3'd3;
   localparam logic [STEP_BITS-1:0] STEP_WAIT = 3'd4;

   localparam logic [1:0] OP_NOP     = 2'd0;
   localparam logic [1:0] OP_MUL_COS = 2'd1;
   localparam logic [1:0] OP_MUL_SIN = 2'd2;
   localparam logic [1:0] OP_EMIT    = 2'd3;

   localparam logic [1:0] COND_NEXT   = 2'd0;  // fall through
   localparam logic [1:0] COND_ACCEPT = 2'd1;  // hold until a request, then jump
   localparam logic [1:0] COND_LOOP   = 2'd2;  // hold on stall, jump back unless last
   localparam logic [1:0] COND_JUMP   = 2'd3;  // jump always

   typedef struct packed {
      logic [1:0]           op;
      logic [1:0]           cond;
      logic [STEP_BITS-1:0] target;
   } ucode_type;

   localparam ucode_type UCODE [UCODE_DEPTH] = '{
      '{OP_NOP,     COND_NEXT,   STEP_MULC},   // read: sine ROM address settles
      '{OP_MUL_COS, COND_NEXT,   STEP_MULS},   // cosine products
      '{OP_MUL_SIN, COND_NEXT,   STEP_EMIT},   // sine products
      '{OP_EMIT,    COND_LOOP,   STEP_READ},   // sum, saturate, emit, advance
      '{OP_NOP,     COND_ACCEPT, STEP_READ},   // wait for a request
      '{OP_NOP,     COND_JUMP,   STEP_WAIT},
      '{OP_NOP,     COND_JUMP,   STEP_WAIT},
      '{OP_NOP,     COND_JUMP,   STEP_WAIT}
   };

   // Polynomial coefficients, Q30
   localparam longint unsigned SIN_C1  = 64'd1686629713;
   localparam longint unsigned SIN_C3  = 64'd693598669;
   localparam longint unsigned SIN_C5  = 64'd85569308;
   localparam longint unsigned SIN_C7  = 64'd5026994;
   localparam longint unsigned SIN_C9  = 64'd172272;
   localparam longint unsigned SIN_C11 = 64'd3864;

   // Quarter-wave sine, argument 0..16384 phase units, result Q14
   function automatic logic signed [15:0] quarter_sine(input longint unsigned x);
      longint unsigned t;
      longint unsigned t2;
      longint unsigned acc;
      longint unsigned r;
      t   = x << 16;
      t2  = (t * t) >> 30;
      acc = SIN_C11;
      acc = SIN_C9 - ((acc * t2) >> 30);
      acc = SIN_C7 - ((acc * t2) >> 30);
      acc = SIN_C5 - ((acc * t2) >> 30);
      acc = SIN_C3 - ((acc * t2) >> 30);
      acc = SIN_C1 - ((acc * t2) >> 30);
      r   = (acc * t) >> 30;
      r   = (r + 64'd32768) >> 16;
      if (r > 64'd16384) r = 64'd16384;
      return 16'(r);
   endfunction

   // Table entry i of a 2^bits entry sine table
   function automatic logic signed [15:0] sine_entry(input int unsigned i,
                                                     input int unsigned bits);
      longint unsigned n;
      longint unsigned phase;
      longint unsigned q;
      longint unsigned x;
      logic signed [15:0] s;
      n     = 64'd1 << bits;
      phase = ((64'(i) & (n - 64'd1)) << (16 - bits)) & 64'hFFFF;
      q     = phase >> 14;
      x     = phase & 64'd16383;
      if (q[0]) s = quarter_sine(64'd16384 - x);
      else      s = quarter_sine(x);
      return q[1] ? -s : s;
   endfunction

endpackage

// ===== design/rsurf_req_if.sv =====
// ---------------------------------------------------------------------------
// Tessellator request channel
// Valid/ready channel carrying one profile point.
// ---------------------------------------------------------------------------
interface rsurf_req_if;
   logic               valid;
   logic               ready;
   logic [5:0]         point_index;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic signed [15:0] coord_z;

   modport source (output valid, point_index, coord_x, coord_y, coord_z,
                   input  ready);
   modport sink   (input  valid, point_index, coord_x, coord_y, coord_z,
                   output ready);
endinterface

// ===== design/rsurf_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Tessellator response channel
// Valid/ready channel carrying one rotated vertex and its two triangles.
// ---------------------------------------------------------------------------
interface rsurf_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        vertex_index;
   logic signed [15:0] rot_x;
   logic signed [15:0] rot_y;
   logic signed [15:0] rot_z;
   logic               faces_valid;
   logic [11:0]        lower_v0;
   logic [11:0]        lower_v1;
   logic [11:0]        lower_v2;
   logic [11:0]        upper_v0;
   logic [11:0]        upper_v1;
   logic [11:0]        upper_v2;
   logic               last_of_run;

   modport source (output valid, vertex_index, rot_x, rot_y, rot_z, faces_valid,
                          lower_v0, lower_v1, lower_v2, upper_v0, upper_v1,
                          upper_v2, last_of_run,
                   input  ready);
   modport sink   (input  valid, vertex_index, rot_x, rot_y, rot_z, faces_valid,
                          lower_v0, lower_v1, lower_v2, upper_v0, upper_v1,
                          upper_v2, last_of_run,
                   output ready);
endinterface

// ===== design/revolution_surface_tessellator_core.sv =====
// ---------------------------------------------------------------------------
// Revolution surface tessellator core
// Each rotation runs the read, cosine, sine and emit microsteps in order; emit
//   holds while the response register is still full, and a new request is
//   taken only once the last rotation of the previous one has been emitted.
// Reset: synchronous; registers return to 16 / 8 / 4096, no clearing pass.
// ---------------------------------------------------------------------------
module revolution_surface_tessellator_core
   import rsurf_pkg::*;
#(
   parameter int MAX_ROTATIONS   = MAX_ROTATIONS_DEF,
   parameter int MAX_PROFILE     = MAX_PROFILE_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   rsurf_req_if.sink               req_ch,
   rsurf_rsp_if.source             rsp_ch,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata
);

   // Configuration registers; the user must write them only while the core is idle; not enforced here
   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   point_type  point;
   ctl_type    ctl;
   status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROTATION_COUNT: cfg_in.rotation_count = csr_wdata[6:0];
            CSR_PROFILE_COUNT:  cfg_in.profile_count  = csr_wdata[6:0];
            CSR_ANGLE_STEP:     cfg_in.angle_step     = csr_wdata;
            default:            cfg_in = cfg_ff;  // drop writes past the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation_count <= ROTATION_COUNT_RST;
         cfg_ff.profile_count  <= PROFILE_COUNT_RST;
         cfg_ff.angle_step     <= ANGLE_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Gather the request payload; the datapath latches it on acceptance
   assign point.point_index = req_ch.point_index;
   assign point.coord_x     = req_ch.coord_x;
   assign point.coord_y     = req_ch.coord_y;
   assign point.coord_z     = req_ch.coord_z;

   // Sequencer: waits for a request, then loops read / cos / sin / emit per
   // rotation, holding in emit while the response register is still full.
   rsurf_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .status (status),
      .ctl    (ctl)
   );

   // Datapath: sine ROM, two multipliers per step, index arithmetic and the
   // response register that decouples the sequencer from the consumer.
   rsurf_datapath #(
      .MAX_ROTATIONS   (MAX_ROTATIONS),
      .MAX_PROFILE     (MAX_PROFILE),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .point  (point),
      .ctl    (ctl),
      .status (status),
      .rsp    (rsp_ch)
   );

endmodule

// ===== design/rsurf_sequencer.sv =====
// ---------------------------------------------------------------------------
// Tessellator microcode sequencer
// Step counter over the microcode ROM with conditional jumps.
// ---------------------------------------------------------------------------
`include "revolution_surface_tessellator_core_defines.svh"

module rsurf_sequencer
   import rsurf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   rsurf_req_if.sink         req,
   input  status_type        status,
   output ctl_type           ctl
);

   logic [STEP_BITS-1:0] step_ff;
   logic [STEP_BITS-1:0] step_in;
   ucode_type            cw;
   logic                 accept;
   logic                 fire;

   assign cw        = UCODE[step_ff];
   assign req.ready = (cw.cond == COND_ACCEPT);
   assign accept    = req.ready && req.valid;
   assign fire      = (cw.op == OP_EMIT) && status.out_free;

   always_comb begin
      case (cw.cond)
         COND_NEXT:   step_in = step_ff + STEP_BITS'(1);
         COND_ACCEPT: step_in = accept ? cw.target : step_ff;
         COND_LOOP: begin
            if (!fire)           step_in = step_ff;
            else if (status.last) step_in = step_ff + STEP_BITS'(1);
            else                 step_in = cw.target;
         end
         COND_JUMP:   step_in = cw.target;
         default:     step_in = STEP_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctl.load    = accept;
   assign ctl.mul_cos = (cw.op == OP_MUL_COS);
   assign ctl.mul_sin = (cw.op == OP_MUL_SIN);
   assign ctl.emit    = fire;

   `RSURF_ASSERT(a_accept_starts_run, clock, reset, accept |=> (step_ff == STEP_READ), "request accepted but run did not start")
   `RSURF_ASSERT(a_last_returns_idle, clock, reset, (fire && status.last) |=> (step_ff == STEP_WAIT), "final rotation did not return to wait")

endmodule

// ===== design/rsurf_datapath.sv =====
// ---------------------------------------------------------------------------
// Tessellator datapath
// Sine ROM, rotation multipliers, index arithmetic and output register.
// ---------------------------------------------------------------------------
`include "revolution_surface_tessellator_core_defines.svh"

module rsurf_datapath
   import rsurf_pkg::*;
#(
   parameter int MAX_ROTATIONS   = MAX_ROTATIONS_DEF,
   parameter int MAX_PROFILE     = MAX_PROFILE_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  point_type  point,
   input  ctl_type    ctl,
   output status_type status,
   rsurf_rsp_if.source rsp
);

   localparam int TABLE_SIZE  = 1 << SINE_TABLE_BITS;
   localparam int ROT_BITS    = $clog2(MAX_ROTATIONS + 1);
   localparam int K_BITS      = $clog2(MAX_ROTATIONS);
   localparam int PROFILE_CAP = (MAX_PROFILE > 127) ? 127 : MAX_PROFILE;
   localparam int M_BITS      = $clog2(PROFILE_CAP + 1);

   // Constant sine ROM, registered reads
   logic signed [15:0] sine_rom [TABLE_SIZE];

   for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
      localparam logic signed [15:0] ENTRY = sine_entry(gi, SINE_TABLE_BITS);
      assign sine_rom[gi] = ENTRY;
   end

   logic [SINE_TABLE_BITS-1:0] sin_addr;
   logic [SINE_TABLE_BITS-1:0] cos_addr;
   logic signed [15:0]         sin_ff;
   logic signed [15:0]         cos_ff;

   // Effective counts
   logic [ROT_BITS-1:0]        r_eff;
   logic [M_BITS-1:0]          m_eff;
   logic [ROT_BITS+M_BITS-1:0] prv_init;

   // Run state
   point_type              point_ff;
   logic [K_BITS-1:0]      k_ff,       k_in;
   logic [15:0]            phase_ff,   phase_in;
   logic [IDX_BITS-1:0]    curbase_ff, curbase_in;
   logic [IDX_BITS-1:0]    prvbase_ff, prvbase_in;

   logic signed [31:0] prod_xc_ff, prod_zc_ff, prod_zs_ff, prod_xs_ff;
   logic signed [31:0] sum_x, sum_z;

   logic [IDX_BITS-1:0] j_ext, cur, prv;
   logic                last;
   result_type          result;
   result_type          out_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      if (v > 32'sd32767)       return 16'sh7FFF;
      else if (v < -32'sd32768) return 16'sh8000;
      else                      return v[15:0];
   endfunction

   assign r_eff = (cfg.rotation_count == 7'd0) ? ROT_BITS'(1) :
                  (cfg.rotation_count > 7'(MAX_ROTATIONS)) ? ROT_BITS'(MAX_ROTATIONS) :
                  ROT_BITS'(cfg.rotation_count);
   assign m_eff = (cfg.profile_count == 7'd0) ? M_BITS'(1) :
                  (cfg.profile_count > 7'(PROFILE_CAP)) ? M_BITS'(PROFILE_CAP) :
                  M_BITS'(cfg.profile_count);
   assign prv_init = (r_eff - ROT_BITS'(1)) * m_eff;

   assign sin_addr = phase_ff[15 -: SINE_TABLE_BITS];
   assign cos_addr = sin_addr + SINE_TABLE_BITS'(TABLE_SIZE / 4);

   always_ff @(posedge clock) begin
      sin_ff <= sine_rom[sin_addr];
      cos_ff <= sine_rom[cos_addr];
   end

   // Products: cosine terms in one step, sine terms in the next
   always_ff @(posedge clock) begin
      if (ctl.mul_cos) begin
         prod_xc_ff <= point_ff.coord_x * cos_ff;
         prod_zc_ff <= point_ff.coord_z * cos_ff;
      end
      if (ctl.mul_sin) begin
         prod_zs_ff <= point_ff.coord_z * sin_ff;
         prod_xs_ff <= point_ff.coord_x * sin_ff;
      end
   end

   assign sum_x = prod_xc_ff + prod_zs_ff;
   assign sum_z = prod_zc_ff - prod_xs_ff;

   assign j_ext = IDX_BITS'(point_ff.point_index);
   assign cur   = curbase_ff + j_ext;
   assign prv   = prvbase_ff + j_ext;
   assign last  = (ROT_BITS'(k_ff) == (r_eff - ROT_BITS'(1)));

   always_comb begin
      result.vertex_index = cur;
      result.rot_x        = sat16(sum_x >>> 14);
      result.rot_y        = point_ff.coord_y;
      result.rot_z        = sat16(sum_z >>> 14);
      result.last_of_run  = last;
      if (point_ff.point_index != 6'd0) begin
         result.faces_valid = 1'b1;
         result.lower_v0    = cur;
         result.lower_v1    = prv;
         result.lower_v2    = prv - IDX_BITS'(1);
         result.upper_v0    = cur;
         result.upper_v1    = prv - IDX_BITS'(1);
         result.upper_v2    = cur - IDX_BITS'(1);
      end else begin
         result.faces_valid = 1'b0;
         result.lower_v0    = '0;
         result.lower_v1    = '0;
         result.lower_v2    = '0;
         result.upper_v0    = '0;
         result.upper_v1    = '0;
         result.upper_v2    = '0;
      end
   end

   // Advance rotation on emit; restart on load
   always_comb begin
      k_in       = k_ff;
      phase_in   = phase_ff;
      curbase_in = curbase_ff;
      prvbase_in = prvbase_ff;
      if (ctl.load) begin
         k_in       = '0;
         phase_in   = '0;
         curbase_in = '0;
         prvbase_in = IDX_BITS'(prv_init);
      end else if (ctl.emit) begin
         k_in       = k_ff + K_BITS'(1);
         phase_in   = phase_ff + cfg.angle_step;
         curbase_in = curbase_ff + IDX_BITS'(m_eff);
         prvbase_in = curbase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         phase_ff <= '0;
      end else begin
         k_ff     <= k_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      curbase_ff <= curbase_in;
      prvbase_ff <= prvbase_in;
      if (ctl.load) point_ff <= point;
      if (ctl.emit) out_ff <= result;
   end

   // Output register
   assign rsp_valid_in = ctl.emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.last     = last;
   assign status.out_free = !rsp_valid_ff || rsp.ready;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.vertex_index = out_ff.vertex_index;
   assign rsp.rot_x        = out_ff.rot_x;
   assign rsp.rot_y        = out_ff.rot_y;
   assign rsp.rot_z        = out_ff.rot_z;
   assign rsp.faces_valid  = out_ff.faces_valid;
   assign rsp.lower_v0     = out_ff.lower_v0;
   assign rsp.lower_v1     = out_ff.lower_v1;
   assign rsp.lower_v2     = out_ff.lower_v2;
   assign rsp.upper_v0     = out_ff.upper_v0;
   assign rsp.upper_v1     = out_ff.upper_v1;
   assign rsp.upper_v2     = out_ff.upper_v2;
   assign rsp.last_of_run  = out_ff.last_of_run;

   `RSURF_ASSERT(a_emit_into_free_slot, clock, reset, ctl.emit |-> (!rsp_valid_ff || rsp.ready), "result loaded over an untaken result")
   `RSURF_ASSERT(a_load_clears_run, clock, reset, ctl.load |=> ((k_ff == '0) && (phase_ff == '0)), "run state not restarted on request")

endmodule

// ===== sim/revolution_surface_tessellator_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Revolution surface tessellator core testbench
// Drives profile point requests through the tessellator under a range of
// rotation, profile and angle settings, predicts every rotated vertex and
// its two triangles, and checks each response in order, field by field.
// ---------------------------------------------------------------------------
module revolution_surface_tessellator_core_tb
   import rsurf_pkg::*;
();

   localparam int TABLE_BITS = SINE_TABLE_BITS_DEF;
   localparam int TABLE_SIZE = 1 << TABLE_BITS;
   localparam int LONG_HOLD  = 400;        // cycles the receiver blocks once
   localparam int PHASE_ITEMS = 45;

   // Taylor coefficients of the quarter-wave sine, Q30, highest order first
   localparam longint unsigned TAYLOR_Q30 [6] = '{
      64'd3864, 64'd172272, 64'd5026994, 64'd85569308, 64'd693598669, 64'd1686629713
   };

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the registers, predicts the vertices of each accepted
   // request and checks the responses against them in order.
   // -------------------------------------------------------------------------
   class tessellation_scoreboard;
      int unsigned rotations;
      int unsigned profile_len;
      int unsigned phase_step;
      int          sine_q14 [TABLE_SIZE];
      result_type  expected_vertices [$];
      int          errors;

      function new();
         rotations   = ROTATION_COUNT_RST;
         profile_len = PROFILE_COUNT_RST;
         phase_step  = ANGLE_STEP_RST;
         errors      = 0;
         for (int i = 0; i < TABLE_SIZE; i++) sine_q14[i] = table_value(i);
      endfunction

      // sine of 0 .. 16384 phase units, Q14
      function int quarter_wave(longint unsigned arg);
         longint unsigned t;
         longint unsigned t2;
         longint unsigned acc;
         t   = arg << 16;
         t2  = (t * t) >> 30;
         acc = TAYLOR_Q30[0];
         for (int n = 1; n < 6; n++) acc = TAYLOR_Q30[n] - ((acc * t2) >> 30);
         acc = (acc * t) >> 30;
         acc = (acc + 64'd32768) >> 16;
         return (acc > 64'd16384) ? 16384 : int'(acc);
      endfunction

      function int table_value(int unsigned i);
         int unsigned phase;
         int unsigned quadrant;
         int unsigned offset;
         int          mag;
         phase    = (i << (16 - TABLE_BITS)) & 32'hFFFF;
         quadrant = phase >> 14;
         offset   = phase & 32'd16383;
         mag      = quadrant[0] ? quarter_wave(16384 - offset) : quarter_wave(offset);
         return quadrant[1] ? -mag : mag;
      endfunction

      function logic signed [15:0] clamp16(longint v);
         if (v > 32767)  return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return 16'(v);
      endfunction

      function int unsigned rotation_copies();
         if (rotations < 1) return 1;
         if (rotations > MAX_ROTATIONS_DEF) return MAX_ROTATIONS_DEF;
         return rotations;
      endfunction

      function int unsigned profile_points();
         if (profile_len < 1) return 1;
         if (profile_len > MAX_PROFILE_DEF) return MAX_PROFILE_DEF;
         return profile_len;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] index, logic [CSR_BITS-1:0] value);
         case (index)
            CSR_ROTATION_COUNT: rotations   = value & 16'h007F;
            CSR_PROFILE_COUNT:  profile_len = value & 16'h007F;
            CSR_ANGLE_STEP:     phase_step  = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_vertices.size();
      endfunction

      function void note_point(point_type pt);
         int unsigned r;
         int unsigned m;
         int unsigned j;
         int unsigned phase;
         int unsigned idx;
         int unsigned prev_rot;
         int unsigned cur;
         int unsigned prv;
         longint      x;
         longint      z;
         longint      s;
         longint      c;
         result_type  v;
         r = rotation_copies();
         m = profile_points();
         j = pt.point_index;
         x = longint'($signed(pt.coord_x));
         z = longint'($signed(pt.coord_z));
         for (int unsigned k = 0; k < r; k++) begin
            phase    = (k * phase_step) & 32'hFFFF;
            idx      = phase >> (16 - TABLE_BITS);
            s        = sine_q14[idx];
            c        = sine_q14[(idx + TABLE_SIZE / 4) & (TABLE_SIZE - 1)];
            prev_rot = (k + r - 1) % r;
            cur      = k * m + j;
            prv      = prev_rot * m + j;
            v              = '0;
            v.vertex_index = IDX_BITS'(cur);
            v.rot_x        = clamp16((x * c + z * s) >>> 14);
            v.rot_y        = pt.coord_y;
            v.rot_z        = clamp16((z * c - x * s) >>> 14);
            if (j >= 1) begin
               v.faces_valid = 1'b1;
               v.lower_v0    = IDX_BITS'(cur);
               v.lower_v1    = IDX_BITS'(prv);
               v.lower_v2    = IDX_BITS'(prv - 1);
               v.upper_v0    = IDX_BITS'(cur);
               v.upper_v1    = IDX_BITS'(prv - 1);
               v.upper_v2    = IDX_BITS'(cur - 1);
            end
            v.last_of_run  = (k == r - 1);
            expected_vertices = {expected_vertices, v};
         end
      endfunction

      function void compare_field(string label, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, want, got);
         end
      endfunction

      function void check_vertex(result_type got);
         result_type want;
         if (expected_vertices.size() == 0) begin
            errors++;
            $display("%0t: vertex_index mismatch: expected none, got %0d",
                     $time, got.vertex_index);
            return;
         end
         want = expected_vertices.pop_front();
         compare_field("vertex_index", want.vertex_index, got.vertex_index);
         compare_field("rot_x",        want.rot_x,        got.rot_x);
         compare_field("rot_y",        want.rot_y,        got.rot_y);
         compare_field("rot_z",        want.rot_z,        got.rot_z);
         compare_field("faces_valid",  want.faces_valid,  got.faces_valid);
         compare_field("lower_v0",     want.lower_v0,     got.lower_v0);
         compare_field("lower_v1",     want.lower_v1,     got.lower_v1);
         compare_field("lower_v2",     want.lower_v2,     got.lower_v2);
         compare_field("upper_v0",     want.upper_v0,     got.upper_v0);
         compare_field("upper_v1",     want.upper_v1,     got.upper_v1);
         compare_field("upper_v2",     want.upper_v2,     got.upper_v2);
         compare_field("last_of_run",  want.last_of_run,  got.last_of_run);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0]     csr_wdata;

   rsurf_req_if req_bus ();
   rsurf_rsp_if rsp_bus ();

   revolution_surface_tessellator_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tessellation_scoreboard sb = new();

   bit steady            = 1'b0;   // both sides run without idling while set
   bit long_hold_pending = 1'b0;   // ask the receiver for one long stall

   initial begin
      forever #5 clock = ~clock;
   end

   // Limit: generous fixed bound on the whole run
   initial begin
      #25_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offer one request after a random gap; return once it is accepted.
   // Valid stays high after acceptance so a zero gap needs no toggle.
   task automatic send_point(point_type pt);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.point_index <= pt.point_index;
      req_bus.coord_x     <= pt.coord_x;
      req_bus.coord_y     <= pt.coord_y;
      req_bus.coord_z     <= pt.coord_z;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.note_point(pt);
   endtask

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         4:       return 16'($urandom_range(0, 1023)) - 16'sd512;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic point_type make_point(int unsigned j, logic signed [15:0] x,
                                            logic signed [15:0] y, logic signed [15:0] z);
      point_type pt;
      pt.point_index = 6'(j);
      pt.coord_x     = x;
      pt.coord_y     = y;
      pt.coord_z     = z;
      return pt;
   endfunction

   function automatic point_type random_point(int unsigned j);
      return make_point(j, rand_coord(), rand_coord(), rand_coord());
   endfunction

   // Drop valid, then hold until every predicted vertex has come out and
   // the pipeline has had time to go quiet.
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // One register write per rising edge; csr_we stays high across a burst.
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] index, logic [CSR_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(index, value);
   endtask

   // Reprogram all three registers while idle. Junk in the unused upper bits
   // of the count registers must be ignored.
   task automatic configure(int unsigned rot, int unsigned prof, int unsigned step);
      settle();
      write_reg(CSR_ROTATION_COUNT, 16'(rot & 7'h7F) | (16'($urandom()) & 16'hFF80));
      write_reg(CSR_PROFILE_COUNT,  16'(prof & 7'h7F) | (16'($urandom()) & 16'hFF80));
      write_reg(CSR_ANGLE_STEP,     16'(step));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly whole profiles j = 0 .. M-1 with random coordinates; the rest
   // single points at random positions. A run cut short by the item count
   // leaves a broken profile, which is fine.
   task automatic run_random_phase(int count);
      int sent;
      int run_len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 4) != 0) begin
            run_len = sb.profile_points();
            for (int j = 0; j < run_len && sent < count; j++) begin
               send_point(random_point(j));
               sent++;
            end
         end else begin
            send_point(random_point($urandom_range(0, 63)));
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side: random stalls, one long stall on request, check each
   // accepted response against the scoreboard.
   // -------------------------------------------------------------------------
   initial begin
      int         stall;
      result_type got;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 10);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            stall = LONG_HOLD;
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (rsp_bus.valid !== 1'b1) @(posedge clock);
         got.vertex_index = rsp_bus.vertex_index;
         got.rot_x        = rsp_bus.rot_x;
         got.rot_y        = rsp_bus.rot_y;
         got.rot_z        = rsp_bus.rot_z;
         got.faces_valid  = rsp_bus.faces_valid;
         got.lower_v0     = rsp_bus.lower_v0;
         got.lower_v1     = rsp_bus.lower_v1;
         got.lower_v2     = rsp_bus.lower_v2;
         got.upper_v0     = rsp_bus.upper_v0;
         got.upper_v1     = rsp_bus.upper_v1;
         got.upper_v2     = rsp_bus.upper_v2;
         got.last_of_run  = rsp_bus.last_of_run;
         sb.check_vertex(got);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      req_bus.valid       = 1'b0;
      req_bus.point_index = '0;
      req_bus.coord_x     = '0;
      req_bus.coord_y     = '0;
      req_bus.coord_z     = '0;
      csr_we              = 1'b0;
      csr_index           = CSR_ROTATION_COUNT;
      csr_wdata           = '0;

      // Hold reset, then release it on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under reset settings (16 rotations, 8 points, 22.5 deg):
      // first point without faces, coordinate extremes that saturate at
      // 45 degrees, negative values that floor, indexes at and past M
      send_point(make_point(0,  16'sh0000, 16'sh0000, 16'sh0000));
      send_point(make_point(1,  16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_point(make_point(2,  16'sh8000, 16'sh8000, 16'sh8000));
      send_point(make_point(3,  16'sh7FFF, 16'sh0100, 16'sh8000));
      send_point(make_point(4,  16'sh8000, -16'sd1,   16'sh7FFF));
      send_point(make_point(0,  -16'sd1,   16'sh0001, -16'sd1));
      send_point(make_point(7,  16'sh0100, -16'sh0100, 16'sh0000));
      send_point(make_point(8,  rand_coord(), rand_coord(), rand_coord()));
      send_point(make_point(63, rand_coord(), rand_coord(), rand_coord()));

      // Rotation count zero behaves as one: a single result per request
      configure(0, 8, 4096);
      send_point(make_point(0, 16'sh7FFF, 16'sh1234, 16'sh8000));
      send_point(make_point(5, 16'sh8000, 16'sh8000, 16'sh7FFF));

      // Counts above the maximum saturate; largest phase step
      configure(127, 127, 16'hFFFF);
      send_point(make_point(63, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_point(make_point(0,  16'sh8000, 16'sh8000, 16'sh8000));

      // Profile count zero behaves as one; zero step keeps every copy at 0 deg
      configure(3, 0, 0);
      send_point(make_point(1, 16'sh8000, 16'sh0000, 16'sh7FFF));
      send_point(make_point(0, 16'sh7FFF, 16'sh7FFF, 16'sh8000));

      // Quarter turns: exact unit sine and cosine, worst-case saturation
      configure(4, 2, 16384);
      send_point(make_point(1, 16'sh8000, 16'sh8000, 16'sh8000));
      send_point(make_point(2, 16'sh7FFF, 16'sh0000, 16'sh8000));

      // Full mesh size, highest vertex index
      configure(64, 64, 1024);
      send_point(make_point(63, 16'sh8000, 16'sh7FFF, 16'sh7FFF));
      send_point(make_point(32, 16'sh7FFF, 16'sh8000, 16'sh8000));

      // Random part
      configure(ROTATION_COUNT_RST, PROFILE_COUNT_RST, ANGLE_STEP_RST);
      run_random_phase(PHASE_ITEMS);

      // Few rotations fill the block fast: stall the receiver for a long
      // stretch here while requests keep coming, so the input backs up
      configure(3, 1, $urandom_range(0, 65535));
      long_hold_pending = 1'b1;
      run_random_phase(PHASE_ITEMS);

      configure(64, 64, $urandom_range(0, 65535));
      steady = 1'b1;
      run_random_phase(PHASE_ITEMS);
      steady = 1'b0;

      for (int ph = 0; ph < 7; ph++) begin
         configure(($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(3, 12),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(1, 12),
                   ($urandom_range(0, 5) == 0) ? 16'hFFFF : $urandom_range(0, 65535));
         steady = (ph == 3);
         run_random_phase(PHASE_ITEMS);
         steady = 1'b0;
      end

      // Drain, give stray responses a chance to show, then report
      settle();
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
